@@ hdl/cmwc_pkg.sv @@
// Shared types and constants for the CMWC4096 random generator.
// Used by cmwc4096_random_generator and its testbench; depends on nothing else.
`default_nettype none
package cmwc_pkg;

    // Default lag table depth.
    localparam int unsigned CMWC_TABLE_DEPTH = 4096;

    // Generator constants.
    localparam logic [31:0] CMWC_PHI        = 32'h9e37_79b9;
    localparam logic [14:0] CMWC_MULT       = 15'd18782;
    localparam logic [31:0] CMWC_R          = 32'hffff_fffe;
    localparam logic [31:0] CMWC_CARRY_INIT = 32'd362436;

    // Request kinds carried on tuser.
    localparam logic OP_SEED = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_SEED_DONE,
        ST_RD,
        ST_MUL,
        ST_FIX
    } t_state;

endpackage
`default_nettype wire

@@ hdl/cmwc4096_random_generator.sv @@
// Top level of the CMWC4096 random generator: lag table memory, carry and
// sequencer. Depends on cmwc_pkg for constants and the state type.
//
// Channel   Direction  Payload
// s_axis    in         tdata[31:0] = seed_value, tuser[0] = op (0 seed, 1 draw)
// m_axis    out        tdata[31:0] = random_word (0 after a seed)
//
// A draw steps the index at acceptance, then passes through a registered
// table read (ST_RD), the 18782 x entry + carry multiply (ST_MUL), and the
// carry fix with write back and the output register load (ST_FIX). A seed
// writes one table entry per cycle through the single write port, then posts
// its result from ST_SEED_DONE. Reset sets the carry to 362436 and the index
// to TABLE_DEPTH-1; the table holds no reset value. New requests are taken
// only in idle, which the sequencer reenters as the result is posted; a result
// waiting on m_axis_tready holds the sequencer in its final state until the
// output register frees.
`default_nettype none
module cmwc4096_random_generator #(
    parameter int unsigned TABLE_DEPTH = cmwc_pkg::CMWC_TABLE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] seed_value
    input  wire logic        s_axis_tuser,   // [0] op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // [31:0] random_word
);
    import cmwc_pkg::*;

    localparam int unsigned IW = $clog2(TABLE_DEPTH);
    localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);

    // Lag table storage.
    logic [31:0] mem [TABLE_DEPTH];

    // Control and data registers.
    t_state        r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_k, n_k;
    logic [31:0]   r_carry, n_carry;
    logic [31:0]   r_seed, n_seed;
    logic [31:0]   r_w0, n_w0, r_w1, n_w1, r_w2, n_w2;
    logic [47:0]   r_t, n_t;
    logic [31:0]   r_rd;
    logic          r_out_valid, n_out_valid;
    logic [31:0]   r_out_data, n_out_data;

    // Write port controls.
    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [31:0]   w_wdata;

    // Seed fill and draw arithmetic.
    logic          out_free;
    logic [31:0]   fill_val;
    logic [31:0]   hi;
    logic [31:0]   x_raw;
    logic          wrap;
    logic [31:0]   x_fix;
    logic [31:0]   carry_fix;

    assign out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        if (r_k == '0) begin
            fill_val = r_seed;
        end else if (r_k < IW'(3)) begin
            fill_val = r_w2 + CMWC_PHI;
        end else begin
            fill_val = r_w0 ^ r_w1 ^ CMWC_PHI ^ 32'(r_k);
        end
    end

    assign hi        = {16'd0, r_t[47:32]};
    assign x_raw     = r_t[31:0] + hi;
    assign wrap      = x_raw < hi;
    assign x_fix     = wrap ? x_raw + 32'd1 : x_raw;
    assign carry_fix = wrap ? hi + 32'd1 : hi;

    // Sequencer: next state, register updates and memory write.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_k         = r_k;
        n_carry     = r_carry;
        n_seed      = r_seed;
        n_w0        = r_w0;
        n_w1        = r_w1;
        n_w2        = r_w2;
        n_t         = r_t;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        w_we        = 1'b0;
        w_waddr     = r_idx;
        w_wdata     = CMWC_R - x_fix;
        s_axis_tready = 1'b0;

        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    if (s_axis_tuser == OP_SEED) begin
                        n_seed  = s_axis_tdata;
                        n_k     = '0;
                        n_state = ST_SEED;
                    end else begin
                        n_idx   = (r_idx == LAST) ? '0 : r_idx + IW'(1);
                        n_state = ST_RD;
                    end
                end
            end
            ST_SEED: begin
                w_we    = 1'b1;
                w_waddr = r_k;
                w_wdata = fill_val;
                n_w0    = r_w1;
                n_w1    = r_w2;
                n_w2    = fill_val;
                n_k     = r_k + IW'(1);
                if (r_k == LAST) begin
                    n_state = ST_SEED_DONE;
                end
            end
            ST_SEED_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    n_state     = ST_IDLE;
                end
            end
            ST_RD: begin
                // Table read issued at r_idx; data lands in r_rd.
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_t     = 48'(CMWC_MULT) * 48'(r_rd) + 48'(r_carry);
                n_state = ST_FIX;
            end
            ST_FIX: begin
                if (out_free) begin
                    w_we        = 1'b1;
                    n_carry     = carry_fix;
                    n_out_valid = 1'b1;
                    n_out_data  = CMWC_R - x_fix;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= LAST;
            r_carry     <= CMWC_CARRY_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_carry     <= n_carry;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_seed     <= n_seed;
        r_w0       <= n_w0;
        r_w1       <= n_w1;
        r_w2       <= n_w2;
        r_t        <= n_t;
        r_out_data <= n_out_data;
    end

    // Lag table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd <= mem[r_idx];
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
`default_nettype wire

@@ tb/cmwc4096_random_generator_tb.sv @@
// Testbench for cmwc4096_random_generator: seeds and draws over the stream ports,
// predicts every result with its own copy of the generator state and checks it.
// Depends on cmwc_pkg and the generator RTL only.
module cmwc4096_random_generator_tb;
    import cmwc_pkg::*;

    localparam int unsigned DEPTH       = CMWC_TABLE_DEPTH;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;     // [31:0] seed_value
    logic        s_axis_tuser  = OP_SEED; // [0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [31:0] random_word

    // Generator state as the testbench tracks it.
    logic [31:0] lag_words [DEPTH];
    logic [31:0] gen_carry = CMWC_CARRY_INIT;
    int unsigned gen_index = DEPTH - 1;

    logic [31:0] expected_words [$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned idle_pct    = 0;
    int unsigned stall_pct   = 0;

    cmwc4096_random_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Work out the word the generator returns for one request and update the state.
    function automatic logic [31:0] predict_word(input logic op, input logic [31:0] seed);
        logic [63:0] product;
        logic [31:0] word;
        logic [31:0] next_carry;
        int unsigned slot;
        if (op == OP_SEED) begin
            lag_words[0] = seed;
            lag_words[1] = seed + CMWC_PHI;
            lag_words[2] = seed + CMWC_PHI + CMWC_PHI;
            for (int unsigned k = 3; k < DEPTH; k++) begin
                lag_words[k] = lag_words[k - 3] ^ lag_words[k - 2] ^ CMWC_PHI ^ 32'(k);
            end
            return '0;
        end
        slot = (gen_index == DEPTH - 1) ? 0 : gen_index + 1;
        gen_index = slot;
        product = 64'(CMWC_MULT) * 64'(lag_words[slot]) + 64'(gen_carry);
        next_carry = product[63:32];
        word = product[31:0] + next_carry;
        // End-around fix when the sum wraps past the carry.
        if (word < next_carry) begin
            word++;
            next_carry++;
        end
        gen_carry = next_carry;
        lag_words[slot] = CMWC_R - word;
        return lag_words[slot];
    endfunction

    // Find a seed whose first draw from entry 0 takes the end-around fix.
    function automatic logic [31:0] find_wrap_seed();
        logic [63:0] target;
        logic [63:0] quotient;
        logic [63:0] product;
        for (int k = 18781; k > 0; k--) begin
            target = ((64'(k) + 64'd1) << 32) - 64'd1;
            quotient = (target - 64'(gen_carry)) / 64'(CMWC_MULT);
            product = 64'(CMWC_MULT) * quotient + 64'(gen_carry);
            if (quotient <= 64'hffff_ffff && product[63:32] == 32'(k)
                    && 33'(product[31:0]) + 33'(k) > 33'h0_ffff_ffff) begin
                return quotient[31:0];
            end
        end
        return 32'h0;
    endfunction

    // Offer one request, wait for its acceptance and record the expected word.
    task automatic send_request(input logic op, input logic [31:0] seed);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= seed;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_words.push_back(predict_word(op, seed));
    endtask

    // Drop the request line and let every expected word arrive.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
    endtask

    // First draw after reset wraps the index to 0 and takes the carry fix.
    task automatic test_wrap_and_carry_fix();
        send_request(OP_SEED, find_wrap_seed());
        repeat (3) send_request(OP_DRAW, $urandom);
    endtask

    // Extreme seed words, and draws with extreme ignored seed fields.
    task automatic test_seed_extremes();
        send_request(OP_SEED, 32'h0000_0000);
        send_request(OP_DRAW, 32'h0000_0000);
        send_request(OP_DRAW, 32'hffff_ffff);
        send_request(OP_DRAW, 32'h5555_5555);
        send_request(OP_SEED, 32'hffff_ffff);
        send_request(OP_DRAW, 32'haaaa_aaaa);
        send_request(OP_DRAW, 32'h0000_0000);
        send_request(OP_SEED, 32'h8000_0001);
        send_request(OP_SEED, 32'h7fff_fffe);
        send_request(OP_DRAW, 32'hffff_ffff);
        send_request(OP_DRAW, 32'h1234_5678);
    endtask

    // Mostly draws with an occasional reseed, under the given idle and stall rates.
    task automatic test_random_traffic(input int unsigned sender_idle,
                                       input int unsigned receiver_stall,
                                       input int unsigned count);
        logic [31:0] seed;
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        for (int unsigned n = 0; n < count; n++) begin
            case ($urandom_range(7))
                0: seed = 32'h0000_0000;
                1: seed = 32'hffff_ffff;
                default: seed = $urandom;
            endcase
            send_request(($urandom_range(99) < 3) ? OP_SEED : OP_DRAW, seed);
        end
    endtask

    // Receiver side: stall at the phase's rate.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Compare each accepted result with the oldest expected word.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, m_axis_tdata);
                error_count++;
            end else begin
                if (m_axis_tdata !== expected_words[0]) begin
                    $display("%0t: random_word mismatch, expected %h, actual %h",
                             $time, expected_words[0], m_axis_tdata);
                    error_count++;
                end
                void'(expected_words.pop_front());
            end
        end
    end

    // Guard against a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_wrap_and_carry_fix();
        test_seed_extremes();
        test_random_traffic(0, 0, 250);
        test_random_traffic(75, 0, 250);
        test_random_traffic(0, 75, 250);
        test_random_traffic(11, 11, 250);
        drain_results();
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && expected_words.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/cmwc_pkg.sv
hdl/cmwc4096_random_generator.sv
tb/cmwc4096_random_generator_tb.sv
